### hw/rtl/nsem_pkg.sv
// Shared types, codes and helpers for the NAL subsample encryption marker.
// Used by nsem_step, nsem_emit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package nsem_pkg;

  localparam int unsigned SizeBitsDefault = 32;
  localparam int unsigned SizeMax         = 32;
  localparam logic [2:0]  LfsReset        = 3'd4;
  localparam logic [2:0]  PrefixMax       = 3'd4;
  localparam logic [7:0]  ByteMask        = 8'hff;

  // Configuration register indexes
  localparam logic REG_LFS = 1'b0;
  localparam logic REG_IV  = 1'b1;

  // Error codes
  localparam logic ERR_SMALL = 1'b0;
  localparam logic ERR_ZERO  = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BURST_DATA  = 2'd0,
    BURST_HDR   = 2'd1,
    BURST_SMALL = 2'd2
  } burst_e;

  // One accepted byte's worth of results, described compactly
  typedef struct packed {
    logic        valid;
    burst_e      mode;
    logic [7:0]  data;
    logic [31:0] prefix;
    logic [2:0]  ps;
    logic        zero_err;
    logic [31:0] prot;
    logic        has_end;
    logic [15:0] total;
    logic [63:0] iv;
    logic [2:0]  last_slot;
  } burst_t;

  function automatic logic [2:0] prefix_size(input logic [2:0] lfs);
    logic [2:0] r;
    if (lfs == 3'd0) begin
      r = 3'd1;
    end else if (lfs > PrefixMax) begin
      r = PrefixMax;
    end else begin
      r = lfs;
    end
    return r;
  endfunction

endpackage

### hw/rtl/nsem_step.sv
// Per-byte parser state: length prefix gathering, NAL size check, frame and IV counters.
// Depends on nsem_pkg; hands one burst descriptor per result-producing byte to nsem_emit.
`timescale 1ns / 1ps

module nsem_step import nsem_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] frame_size_i,
  output burst_t      burst_o
);

  phase_e                 phase_q, phase_d;
  logic [2:0]             lfs_q, lfs_d;
  logic [2:0]             len_left_q, len_left_d;
  logic [SIZE_BITS-1:0]   nal_q, nal_d;
  logic [SIZE_BITS-1:0]   frame_q, frame_d;
  logic [15:0]            sub_q, sub_d;
  logic [63:0]            iv_q, iv_d;
  logic                   err_q, err_d;

  logic [2:0]             ps;
  logic [SIZE_BITS:0]     need;
  logic                   too_small;
  logic [SIZE_BITS-1:0]   frame_sub;
  logic [SIZE_BITS-1:0]   nal_dec;
  logic                   nal_zero;
  logic [15:0]            sub_inc;
  logic                   type_end;
  logic [SIZE_BITS-1:0]   data_nal_next;
  logic                   data_fin;
  logic                   data_end;
  logic                   work;

  assign ps            = prefix_size(lfs_q);
  assign need          = {1'b0, nal_q} + (SIZE_BITS+1)'(ps);
  assign too_small     = {1'b0, frame_q} < need;
  assign frame_sub     = frame_q - need[SIZE_BITS-1:0];
  assign nal_zero      = (nal_q == '0);
  assign nal_dec       = nal_q - SIZE_BITS'(1);
  assign sub_inc       = sub_q + 16'd1;
  assign type_end      = (nal_dec == '0) && (frame_sub == '0);
  assign data_nal_next = nal_zero ? nal_q : nal_dec;
  assign data_fin      = (data_nal_next == '0);
  assign data_end      = data_fin && (frame_q == '0);
  assign work          = accept_i && !err_q;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    lfs_d      = lfs_q;
    len_left_d = len_left_q;
    nal_d      = nal_q;
    frame_d    = frame_q;
    sub_d      = sub_q;
    iv_d       = iv_q;
    err_d      = err_q;
    if (cfg_we_i) begin
      if (cfg_addr_i == REG_LFS) begin
        lfs_d      = cfg_wdata_i[2:0];
        phase_d    = PH_LENGTH;
        len_left_d = prefix_size(cfg_wdata_i[2:0]);
        nal_d      = '0;
      end else begin
        iv_d = cfg_wdata_i;
      end
    end else if (work) begin
      unique case (phase_q)
        PH_LENGTH: begin
          if ((len_left_q == ps) && (frame_q == '0)) begin
            frame_d = frame_size_i[SIZE_BITS-1:0];
            sub_d   = '0;
          end
          nal_d = {nal_q[SIZE_BITS-9:0], data_byte_i};
          if (len_left_q != 3'd0) begin
            len_left_d = len_left_q - 3'd1;
          end
          if (len_left_q <= 3'd1) begin
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (too_small) begin
            err_d = 1'b1;
          end else begin
            frame_d = frame_sub;
            if (nal_zero) begin
              err_d = 1'b1;
            end else begin
              nal_d   = nal_dec;
              sub_d   = sub_inc;
              phase_d = PH_DATA;
              if (nal_dec == '0) begin
                phase_d    = PH_LENGTH;
                len_left_d = ps;
                if (frame_sub == '0) begin
                  iv_d = iv_q + 64'd1;
                end
              end
            end
          end
        end
        PH_DATA: begin
          nal_d = data_nal_next;
          if (data_fin) begin
            phase_d    = PH_LENGTH;
            len_left_d = ps;
            if (frame_q == '0) begin
              iv_d = iv_q + 64'd1;
            end
          end
        end
        default: begin
          phase_d = PH_LENGTH;
        end
      endcase
    end
  end

  // Burst descriptor for the results of this byte
  always_comb begin
    burst_o = '0;
    if (work) begin
      unique case (phase_q)
        PH_TYPE: begin
          burst_o.valid = 1'b1;
          if (too_small) begin
            burst_o.mode = BURST_SMALL;
          end else begin
            burst_o.mode      = BURST_HDR;
            burst_o.data      = data_byte_i;
            burst_o.prefix    = SizeMax'(nal_q);
            burst_o.ps        = ps;
            burst_o.zero_err  = nal_zero;
            burst_o.prot      = SizeMax'(nal_dec);
            burst_o.has_end   = !nal_zero && type_end;
            burst_o.total     = sub_inc;
            burst_o.iv        = iv_q;
            burst_o.last_slot = ps + 3'd1 + {2'b0, burst_o.has_end};
          end
        end
        PH_DATA: begin
          burst_o.valid     = 1'b1;
          burst_o.mode      = BURST_DATA;
          burst_o.data      = data_byte_i;
          burst_o.has_end   = data_end;
          burst_o.total     = sub_q;
          burst_o.iv        = iv_q;
          burst_o.last_slot = {2'b0, data_end};
        end
        default: begin
          burst_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LENGTH;
      lfs_q      <= LfsReset;
      len_left_q <= prefix_size(LfsReset);
      nal_q      <= '0;
      frame_q    <= '0;
      sub_q      <= '0;
      iv_q       <= '0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      lfs_q      <= lfs_d;
      len_left_q <= len_left_d;
      nal_q      <= nal_d;
      frame_q    <= frame_d;
      sub_q      <= sub_d;
      iv_q       <= iv_d;
      err_q      <= err_d;
    end
  end

  // An error stays latched until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("error latch cleared");

  // Once latched, no byte produces results
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !burst_o.valid) else $error("results after latched error");

endmodule

### hw/rtl/nsem_emit.sv
// Burst serializer and output register: expands one descriptor into result transactions.
// Depends on nsem_pkg; fed by nsem_step.
`timescale 1ns / 1ps

module nsem_emit import nsem_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  burst_t       burst_i,
  output logic         burst_ready_o,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [127:0] m_tdata_o,
  output logic [1:0]   m_tuser_o,
  output logic         m_tlast_o
);

  burst_t       desc_q;
  logic         desc_vld_q;
  logic [2:0]   cur_q;
  logic         out_vld_q;
  logic [127:0] tdata_q, tdata_d;
  logic [1:0]   tuser_q, tuser_d;
  logic         tlast_q;

  logic         out_load;
  logic         done;
  logic [2:0]   sel;
  logic [31:0]  pfx_shift;
  logic [7:0]   r_byte;
  logic         r_enc;
  logic [2:0]   r_clr;
  logic [31:0]  r_prot;
  logic [15:0]  r_total;
  logic [63:0]  r_iv;
  logic         r_err;

  assign out_load      = desc_vld_q && (!out_vld_q || m_tready_i);
  assign done          = out_load && (cur_q == desc_q.last_slot);
  assign burst_ready_o = !desc_vld_q || done;

  assign sel       = desc_q.ps - 3'd1 - cur_q;
  assign pfx_shift = desc_q.prefix >> {sel[1:0], 3'b000};

  // Pick the result at the cursor
  always_comb begin
    tuser_d = KIND_BYTE;
    r_byte  = '0;
    r_enc   = 1'b0;
    r_clr   = '0;
    r_prot  = '0;
    r_total = '0;
    r_iv    = '0;
    r_err   = ERR_SMALL;
    case (desc_q.mode)
      BURST_DATA: begin
        if (cur_q == 3'd0) begin
          r_byte = desc_q.data;
          r_enc  = 1'b1;
        end else begin
          tuser_d = KIND_END;
          r_total = desc_q.total;
          r_iv    = desc_q.iv;
        end
      end
      BURST_HDR: begin
        if (cur_q < desc_q.ps) begin
          r_byte = pfx_shift[7:0] & ByteMask;
        end else if (cur_q == desc_q.ps) begin
          r_byte = desc_q.data;
        end else if (cur_q == desc_q.ps + 3'd1) begin
          if (desc_q.zero_err) begin
            tuser_d = KIND_ERR;
            r_err   = ERR_ZERO;
          end else begin
            tuser_d = KIND_SUB;
            r_clr   = desc_q.ps + 3'd1;
            r_prot  = desc_q.prot;
          end
        end else begin
          tuser_d = KIND_END;
          r_total = desc_q.total;
          r_iv    = desc_q.iv;
        end
      end
      default: begin
        tuser_d = KIND_ERR;
        r_err   = ERR_SMALL;
      end
    endcase
    tdata_d = {3'b000, r_err, r_iv, r_total, r_prot, r_clr, r_enc, r_byte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_vld_q <= 1'b0;
      cur_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (burst_i.valid && burst_ready_o) begin
        desc_vld_q <= 1'b1;
        cur_q      <= '0;
      end else if (done) begin
        desc_vld_q <= 1'b0;
      end else if (out_load) begin
        cur_q <= cur_q + 3'd1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_i.valid && burst_ready_o) begin
      desc_q <= burst_i;
    end
    if (out_load) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
      tlast_q <= (cur_q == desc_q.last_slot);
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;
  assign m_tlast_o  = tlast_q;

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_vld_q |-> cur_q <= desc_q.last_slot) else $error("cursor past burst end");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_i.valid |-> burst_ready_o) else $error("burst offered while busy");

  a_last_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> m_tvalid_o && m_tlast_o) else $error("burst end without tlast");

endmodule

### hw/rtl/nal_subsample_encrypt_marker_core.sv
// NAL subsample encryption marker: top level, parser state plus result serializer.
// Depends on nsem_pkg, nsem_step and nsem_emit.
// Each burst descriptor is registered in nsem_emit ahead of the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and no
// receiver stall occurs; a byte with more results holds tready low until its last result
// loads; a NAL type byte yields up to 7 results, the last payload byte of a frame 2.
// Reset (rst_ni, async active low): prefix size 4, IV 0, all counters and error clear.
`timescale 1ns / 1ps

module nal_subsample_encrypt_marker_core import nsem_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: index 0 length field size, index 1 initial IV
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [63:0]  cfg_wdata_i,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [7:0] data_byte, [39:8] frame_size
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [7:0] out_byte, [8] encrypt_flag, [11:9] clear_bytes,
                                  // [43:12] protected_bytes, [59:44] subsample_total,
                                  // [123:60] sample_iv, [124] error_code, rest zero
  output logic [1:0]   m_tuser,   // [1:0] kind
  output logic         m_tlast    // last result of the input transaction
);

  burst_t burst;
  logic   burst_ready;
  logic   accept;

  // Take a byte whenever the serializer can hold its burst
  assign s_tready = burst_ready;
  assign accept   = s_tvalid && burst_ready;

  nsem_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .data_byte_i  (s_tdata[7:0]),
    .frame_size_i (s_tdata[39:8]),
    .burst_o      (burst)
  );

  // Expand the burst into result transactions behind an output register
  nsem_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .burst_ready_o (burst_ready),
    .m_tvalid_o    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_o     (m_tdata),
    .m_tuser_o     (m_tuser),
    .m_tlast_o     (m_tlast)
  );

endmodule

### sim/tb_top.sv
// Self-checking bench for the NAL subsample encryption marker (nal_subsample_encrypt_marker_core).
// Drives framed, length-prefixed NAL byte streams, predicts every result and compares in order.
// Depends on nsem_pkg for the kind and phase codes and the register indexes.
`timescale 1ns / 1ps

module tb_top import nsem_pkg::*; ();

  localparam int DrainCycles = 8;

  // One predicted result transaction
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  obyte;
    logic        enc;
    logic [2:0]  clr;
    logic [31:0] prot;
    logic [15:0] total;
    logic [63:0] iv;
    logic        code;
    logic        last;
  } marker_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_addr_i;
  logic [63:0]  cfg_wdata_i;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // [7:0] data_byte, [39:8] frame_size
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // [7:0] out_byte, [8] encrypt_flag, [11:9] clear_bytes,
                           // [43:12] protected_bytes, [59:44] subsample_total,
                           // [123:60] sample_iv, [124] error_code
  logic [1:0]   m_tuser;   // [1:0] kind
  logic         m_tlast;

  // Shadow copy of the marker state and its registers
  logic [2:0]  mdl_lfs;
  phase_e      mdl_phase;
  logic [2:0]  mdl_len_left;
  logic [31:0] mdl_nal_left;
  logic [31:0] mdl_frame_left;
  logic [15:0] mdl_sub_cnt;
  logic [63:0] mdl_iv;
  logic        mdl_err;

  marker_t     step_markers[$];
  marker_t     pending_markers[$];

  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned bytes_sent;
  int unsigned mismatch_cnt;
  int unsigned kind_seen[4];
  string       err_path;

  nal_subsample_encrypt_marker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_tready <= (sink_stall_pct == 0) || ($urandom_range(99, 0) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Prefix bytes actually used for a register code: 0 reads as 1, above 4 as 4
  function automatic logic [2:0] eff_prefix(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      3'd0:                n = 3'd1;
      3'd1, 3'd2, 3'd3:    n = code;
      default:             n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic void add_marker(input kind_e k, input logic [7:0] ob, input logic en,
                                     input logic [2:0] cl, input logic [31:0] pr,
                                     input logic [15:0] tot, input logic [63:0] ivv,
                                     input logic cd);
    marker_t m;
    m.kind  = k;
    m.obyte = ob;
    m.enc   = en;
    m.clr   = cl;
    m.prot  = pr;
    m.total = tot;
    m.iv    = ivv;
    m.code  = cd;
    m.last  = 1'b0;
    step_markers.push_back(m);
  endfunction

  // NAL payload done: rearm the prefix gatherer, close the frame if it is used up
  function automatic void close_nal();
    mdl_phase    = PH_LENGTH;
    mdl_len_left = eff_prefix(mdl_lfs);
    mdl_nal_left = '0;
    if (mdl_frame_left == 0) begin
      add_marker(KIND_END, 8'd0, 1'b0, 3'd0, 32'd0, mdl_sub_cnt, mdl_iv, 1'b0);
      mdl_iv = mdl_iv + 64'd1;
    end
  endfunction

  // Advance the shadow state by one accepted byte and queue the markers it yields
  function automatic void predict_markers(input logic [7:0] b, input logic [31:0] fs);
    logic [2:0]  ps;
    logic [32:0] need;
    int          k;
    marker_t     m;
    ps = eff_prefix(mdl_lfs);
    if (!mdl_err) begin
      case (mdl_phase)
        PH_LENGTH: begin
          if (mdl_len_left == ps && mdl_frame_left == 0) begin
            mdl_frame_left = fs;
            mdl_sub_cnt    = '0;
          end
          mdl_nal_left = {mdl_nal_left[23:0], b};
          if (mdl_len_left != 0) mdl_len_left = mdl_len_left - 3'd1;
          if (mdl_len_left == 0) mdl_phase = PH_TYPE;
        end
        PH_TYPE: begin
          need = {30'd0, ps} + {1'b0, mdl_nal_left};
          if ({1'b0, mdl_frame_left} < need) begin
            add_marker(KIND_ERR, 8'd0, 1'b0, 3'd0, 32'd0, 16'd0, 64'd0, ERR_SMALL);
            mdl_err = 1'b1;
          end else begin
            mdl_frame_left = mdl_frame_left - need[31:0];
            // Re-emit the prefix most significant byte first, then the header byte
            for (k = int'(ps); k > 0; k--) begin
              add_marker(KIND_BYTE, 8'(mdl_nal_left >> ((k - 1) * 8)), 1'b0, 3'd0, 32'd0,
                         16'd0, 64'd0, 1'b0);
            end
            add_marker(KIND_BYTE, b, 1'b0, 3'd0, 32'd0, 16'd0, 64'd0, 1'b0);
            if (mdl_nal_left == 0) begin
              add_marker(KIND_ERR, 8'd0, 1'b0, 3'd0, 32'd0, 16'd0, 64'd0, ERR_ZERO);
              mdl_err = 1'b1;
            end else begin
              mdl_nal_left = mdl_nal_left - 32'd1;
              add_marker(KIND_SUB, 8'd0, 1'b0, ps + 3'd1, mdl_nal_left, 16'd0, 64'd0, 1'b0);
              mdl_sub_cnt = mdl_sub_cnt + 16'd1;
              mdl_phase   = PH_DATA;
              if (mdl_nal_left == 0) close_nal();
            end
          end
        end
        default: begin
          add_marker(KIND_BYTE, b, 1'b1, 3'd0, 32'd0, 16'd0, 64'd0, 1'b0);
          if (mdl_nal_left != 0) mdl_nal_left = mdl_nal_left - 32'd1;
          if (mdl_nal_left == 0) close_nal();
        end
      endcase
    end
    // Flag the final marker of this byte and hand the burst to the checker
    while (step_markers.size() != 0) begin
      m      = step_markers.pop_front();
      m.last = (step_markers.size() == 0);
      pending_markers.push_back(m);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    marker_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      kind_seen[m_tuser]++;
      if (pending_markers.size() == 0) begin
        $error("kind mismatch: expected no transaction, actual kind %0d", m_tuser);
        mismatch_cnt++;
      end else begin
        want = pending_markers.pop_front();
        check_field("kind", want.kind, m_tuser);
        check_field("out_byte", want.obyte, m_tdata[7:0]);
        check_field("encrypt_flag", want.enc, m_tdata[8]);
        check_field("clear_bytes", want.clr, m_tdata[11:9]);
        check_field("protected_bytes", want.prot, m_tdata[43:12]);
        check_field("subsample_total", want.total, m_tdata[59:44]);
        check_field("sample_iv", want.iv, m_tdata[123:60]);
        check_field("error_code", want.code, m_tdata[124]);
        check_field("tdata_pad", 64'd0, m_tdata[127:125]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus primitives (all entered and left on a falling edge)
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic [31:0] fs);
    while (src_gap_pct != 0 && $urandom_range(99, 0) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {fs, b};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_markers(b, fs);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Prefix (big-endian, frame size on its first byte), header byte, random payload
  task automatic send_nal(input logic [31:0] len, input logic [31:0] fs,
                          input logic [7:0] hdr, input int unsigned n_pay);
    logic [2:0]  ps;
    int          k;
    int unsigned i;
    ps = eff_prefix(mdl_lfs);
    for (k = int'(ps); k > 0; k--) begin
      send_byte(8'(len >> ((k - 1) * 8)), (k == int'(ps)) ? fs : $urandom);
    end
    send_byte(hdr, $urandom);
    for (i = 0; i < n_pay; i++) send_byte(8'($urandom), $urandom);
  endtask

  // Hold off the sender until every predicted transaction has come out
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending_markers.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LFS) begin
      mdl_lfs      = val[2:0];
      mdl_phase    = PH_LENGTH;
      mdl_len_left = eff_prefix(mdl_lfs);
      mdl_nal_left = '0;
    end else begin
      mdl_iv = val;
    end
    @(negedge clk_i);
  endtask

  task automatic load_random_config();
    logic [63:0] ivv;
    case ($urandom_range(3, 0))
      0:       ivv = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(3, 0));
      1:       ivv = '0;
      default: ivv = {$urandom, $urandom};
    endcase
    write_reg(REG_LFS, 64'($urandom_range(7, 0)));
    write_reg(REG_IV, ivv);
  endtask

  // One well-formed frame, or the NAL that exactly closes a frame left open with slack
  task automatic send_random_frame();
    logic [2:0]  ps;
    int unsigned n;
    int unsigned sz[4];
    int unsigned tot;
    logic [31:0] fs;
    int unsigned i;
    ps = eff_prefix(mdl_lfs);
    if (mdl_frame_left != 0) begin
      send_nal(mdl_frame_left - ps, $urandom, 8'($urandom), mdl_frame_left - ps - 1);
    end else begin
      n   = $urandom_range(4, 1);
      tot = 0;
      for (i = 0; i < n; i++) begin
        sz[i] = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1);
        tot   = tot + ps + sz[i];
      end
      fs = tot;
      // Now and then declare a larger frame so that it stays open past these NALs
      if ($urandom_range(9, 0) == 0) fs = fs + ps + $urandom_range(7, 1);
      for (i = 0; i < n; i++) begin
        send_nal(sz[i], (i == 0) ? fs : $urandom, 8'($urandom), sz[i] - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-up registers: four-byte prefix, IV 0; one NAL with a single payload byte
  task automatic test_reset_defaults();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_nal(32'd2, 32'd6, 8'h00, 0);
    send_byte(8'hff, 32'hffff_ffff);
    hold_until_drained();
  endtask

  // Prefix codes at and beyond the legal range, IV at its top and wrapping
  task automatic test_prefix_codes();
    write_reg(REG_LFS, 64'd1);
    write_reg(REG_IV, 64'hffff_ffff_ffff_ffff);
    send_nal(32'd1, 32'd2, 8'hff, 0);
    hold_until_drained();
    write_reg(REG_LFS, 64'd0);
    send_nal(32'd1, 32'd2, 8'h80, 0);
    hold_until_drained();
    write_reg(REG_LFS, 64'd7);
    send_nal(32'd1, 32'd5, 8'h7f, 0);
    hold_until_drained();
    // Two NALs in one frame
    write_reg(REG_LFS, 64'd3);
    send_nal(32'd1, 32'd9, 8'h01, 0);
    send_nal(32'd2, $urandom, 8'hfe, 0);
    send_byte(8'h00, 32'd0);
    hold_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    int unsigned start;
    load_random_config();
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
    start          = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      send_random_frame();
      if ($urandom_range(24, 0) == 0) hold_until_drained();
      if (mdl_frame_left == 0 && $urandom_range(11, 0) == 0) begin
        hold_until_drained();
        load_random_config();
      end
    end
    // Close a frame left open with slack before the prefix size changes again
    if (mdl_frame_left != 0) send_random_frame();
    hold_until_drained();
  endtask

  // Frame and NAL sizes with the top bits set; abort the payload by rewriting the prefix size
  task automatic test_large_nal();
    logic [31:0] fs;
    src_gap_pct    = 10;
    sink_stall_pct = 10;
    write_reg(REG_LFS, 64'd4);
    fs = {1'b1, 31'($urandom)};
    send_nal(fs - 32'd4, fs, 8'($urandom), $urandom_range(8, 2));
    hold_until_drained();
    write_reg(REG_LFS, 64'($urandom_range(7, 0)));
  endtask

  // Only reset clears a latched error, so one error path per run, picked at random
  task automatic test_error_latch();
    logic [2:0]  ps;
    int unsigned len;
    src_gap_pct    = 10;
    sink_stall_pct = 10;
    write_reg(REG_LFS, 64'($urandom_range(7, 0)));
    ps = eff_prefix(mdl_lfs);
    case ($urandom_range(2, 0))
      0: begin
        err_path = "frame too small";
        len      = $urandom_range(40, 1);
        send_nal(len, $urandom_range(ps + len - 1, 1), 8'($urandom), 0);
      end
      1: begin
        err_path = "zero-size NAL";
        send_nal(32'd0, ps + $urandom_range(20, 0), 8'($urandom), 0);
      end
      default: begin
        err_path = "zero frame size";
        send_nal($urandom_range(40, 0), 32'd0, 8'($urandom), 0);
      end
    endcase
    // Everything after the error must be swallowed
    repeat (16) send_byte(8'($urandom), $urandom);
    hold_until_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = REG_LFS;
    cfg_wdata_i    = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b1;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    mismatch_cnt   = 0;
    err_path       = "none";
    mdl_lfs        = LfsReset;
    mdl_phase      = PH_LENGTH;
    mdl_len_left   = eff_prefix(LfsReset);
    mdl_nal_left   = '0;
    mdl_frame_left = '0;
    mdl_sub_cnt    = '0;
    mdl_iv         = '0;
    mdl_err        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_prefix_codes();
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 87, 0);
    test_random_traffic(100, 0, 87);
    test_random_traffic(100, 10, 10);
    test_large_nal();
    test_error_latch();

    repeat (DrainCycles) @(negedge clk_i);
    $display("Summary: %0d input bytes; %0d stream bytes, %0d subsample records, %0d frame ends,",
             bytes_sent, kind_seen[KIND_BYTE], kind_seen[KIND_SUB], kind_seen[KIND_END]);
    $display("  %0d errors; prefix codes 0-7, IV wrap, error path: %s",
             kind_seen[KIND_ERR], err_path);
    if (mismatch_cnt == 0 && pending_markers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### nal_subsample_encrypt_marker_core.f
hw/rtl/nsem_pkg.sv
hw/rtl/nsem_step.sv
hw/rtl/nsem_emit.sv
hw/rtl/nal_subsample_encrypt_marker_core.sv
sim/tb_top.sv
